>>> hdl/nfea_pkg.sv
// Shared constants, status codes and controller/datapath command types
// for the next-fit extent allocator. No dependencies.
`default_nettype none

package nfea_pkg;

    // map size and derived widths
    localparam int NUM_BLOCKS = 1024;
    localparam int ADDR_W     = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
    localparam int SIZE_W     = 11;
    localparam int BADDR_W    = 10;
    localparam int STATUS_W   = 2;
    localparam int CALC_W     = (ADDR_W > SIZE_W) ? ADDR_W : SIZE_W;

    localparam logic [ADDR_W-1:0] LAST_BLOCK = ADDR_W'(NUM_BLOCKS - 1);

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd2;

    // command codes of the input word
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic                clr_step;
        logic                in_load;
        logic                free_wr;
        logic                scan_init;
        logic                scan_from_ptr;
        logic                scan_run;
        logic                mark_run;
        logic                out_load;
        logic [STATUS_W-1:0] out_code;
        logic                out_ext;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic size_zero;
        logic size_big;
        logic found;
        logic scan_end;
        logic mark_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hdl/nfea_dpath.sv
// Datapath of the next-fit extent allocator: bitmap memory, scan pipeline,
// mark counter, next-fit pointer and result register. Uses nfea_pkg.
`default_nettype none

module nfea_dpath import nfea_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    input  wire logic                i_command,
    input  wire logic [SIZE_W-1:0]   i_request_size,
    input  wire logic [BADDR_W-1:0]  i_block_address,
    input  wire logic                i_out_stall,
    output logic                     o_out_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic [BADDR_W-1:0]       o_extent_first,
    output logic [BADDR_W-1:0]       o_extent_last
);

    // latched input word
    logic                r_command;
    logic [SIZE_W-1:0]   r_size;
    logic [BADDR_W-1:0]  r_baddr;

    // pointer, scan and mark registers
    logic [ADDR_W-1:0]   r_ptr;
    logic [ADDR_W-1:0]   r_wr_addr;
    logic [ADDR_W-1:0]   r_first;
    logic [ADDR_W-1:0]   r_last;
    logic [ADDR_W-1:0]   r_iss_addr;
    logic                r_iss_vld;
    logic [ADDR_W-1:0]   r_ev_addr;
    logic                r_ev_vld;
    logic                r_rd_data;
    logic [SIZE_W-1:0]   r_run;

    // result register
    logic                r_out_vld;
    logic [STATUS_W-1:0] r_status;
    logic [BADDR_W-1:0]  r_ext_first;
    logic [BADDR_W-1:0]  r_ext_last;

    // bitmap: one used bit per block
    logic                r_mem [NUM_BLOCKS];

    logic [SIZE_W-1:0]   run_inc;
    logic                hit;
    logic                scan_end;
    logic [CALC_W-1:0]   first_calc;
    logic                free_in_map;
    logic [ADDR_W-1:0]   free_idx;
    logic                mark_done;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                wr_data;
    logic                rd_en;

    // evaluate the bit that came back from the memory
    assign run_inc    = r_run + SIZE_W'(1);
    assign hit        = r_ev_vld && !r_rd_data && (run_inc == r_size);
    assign scan_end   = r_ev_vld && (r_ev_addr == LAST_BLOCK) && !hit;
    assign first_calc = CALC_W'(r_ev_addr) + CALC_W'(1) - CALC_W'(r_size);

    assign free_in_map = int'(r_baddr) < NUM_BLOCKS;
    assign free_idx    = ADDR_W'(r_baddr);
    assign mark_done   = (r_wr_addr == r_last);

    // pick the single write of this cycle
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wr_addr;
        wr_data = 1'b0;
        if (i_cmd.clr_step) begin
            wr_en = 1'b1;
        end else if (i_cmd.free_wr && free_in_map) begin
            wr_en   = 1'b1;
            wr_addr = free_idx;
        end else if (i_cmd.mark_run) begin
            wr_en   = 1'b1;
            wr_data = 1'b1;
        end
    end

    assign rd_en = i_cmd.scan_run && r_iss_vld;

    // bitmap memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_iss_addr];
        end
    end

    // latch the accepted input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_command <= i_command;
            r_size    <= i_request_size;
            r_baddr   <= i_block_address;
        end
    end

    // sweep, scan and mark sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_wr_addr <= '0;
            r_iss_vld <= 1'b0;
            r_ev_vld  <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_wr_addr <= (r_wr_addr == LAST_BLOCK) ? '0 : r_wr_addr + ADDR_W'(1);
            end

            if (i_cmd.scan_init) begin
                r_iss_addr <= i_cmd.scan_from_ptr ? r_ptr : '0;
                r_iss_vld  <= 1'b1;
                r_ev_vld   <= 1'b0;
                r_run      <= '0;
            end else if (i_cmd.scan_run) begin
                // advance the read address, stop at the end of the map
                if (r_iss_vld) begin
                    if (r_iss_addr == LAST_BLOCK) begin
                        r_iss_vld <= 1'b0;
                    end else begin
                        r_iss_addr <= r_iss_addr + ADDR_W'(1);
                    end
                end
                r_ev_vld  <= r_iss_vld;
                r_ev_addr <= r_iss_addr;
                if (r_ev_vld) begin
                    r_run <= r_rd_data ? '0 : run_inc;
                end
                if (hit) begin
                    r_first   <= first_calc[ADDR_W-1:0];
                    r_wr_addr <= first_calc[ADDR_W-1:0];
                    r_last    <= r_ev_addr;
                end
            end

            // mark the run used, then move the pointer past it
            if (i_cmd.mark_run) begin
                if (mark_done) begin
                    r_ptr <= (r_last == LAST_BLOCK) ? '0 : r_last + ADDR_W'(1);
                end else begin
                    r_wr_addr <= r_wr_addr + ADDR_W'(1);
                end
            end
        end
    end

    // result register, held while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_status    <= i_cmd.out_code;
            r_ext_first <= i_cmd.out_ext ? BADDR_W'(r_first) : '0;
            r_ext_last  <= i_cmd.out_ext ? BADDR_W'(r_last) : '0;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.clr_done  = (r_wr_addr == LAST_BLOCK);
        o_sts.is_free   = (r_command == CMD_FREE);
        o_sts.size_zero = (r_size == '0);
        o_sts.size_big  = int'(r_size) > NUM_BLOCKS;
        o_sts.found     = hit;
        o_sts.scan_end  = scan_end;
        o_sts.mark_done = mark_done;
        o_sts.out_free  = !r_out_vld || !i_out_stall;
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_status;
    assign o_extent_first = r_ext_first;
    assign o_extent_last  = r_ext_last;

endmodule

`default_nettype wire

>>> hdl/nfea_ctrl.sv
// Controller of the next-fit extent allocator: clearing sweep, command
// dispatch, two-pass scan, marking and result hand-off. Uses nfea_pkg.
`default_nettype none

module nfea_ctrl import nfea_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_SCAN1    = 3'd3;
    localparam logic [2:0] S_SCAN2    = 3'd4;
    localparam logic [2:0] S_MARK     = 3'd5;
    localparam logic [2:0] S_RESP     = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [STATUS_W-1:0] r_code, n_code;
    logic                r_ext, n_ext;

    assign o_in_stall = (r_state != S_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_ext   = r_ext;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_ext = 1'b0;
                if (i_sts.is_free) begin
                    o_cmd.free_wr = 1'b1;
                    n_code        = ST_DONE;
                    n_state       = S_RESP;
                end else if (i_sts.size_zero) begin
                    n_code  = ST_ZERO;
                    n_state = S_RESP;
                end else if (i_sts.size_big) begin
                    n_code  = ST_NOFIT;
                    n_state = S_RESP;
                end else begin
                    o_cmd.scan_init     = 1'b1;
                    o_cmd.scan_from_ptr = 1'b1;
                    n_state             = S_SCAN1;
                end
            end
            S_SCAN1: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.found) begin
                    n_state = S_MARK;
                end else if (i_sts.scan_end) begin
                    // wrap once and search again from block zero
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN2;
                end
            end
            S_SCAN2: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.found) begin
                    n_state = S_MARK;
                end else if (i_sts.scan_end) begin
                    n_code  = ST_NOFIT;
                    n_state = S_RESP;
                end
            end
            S_MARK: begin
                o_cmd.mark_run = 1'b1;
                if (i_sts.mark_done) begin
                    n_code  = ST_DONE;
                    n_ext   = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_code = r_code;
                    o_cmd.out_ext  = r_ext;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= ST_DONE;
            r_ext   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_ext   <= n_ext;
        end
    end

endmodule

`default_nettype wire

>>> hdl/next_fit_extent_allocator.sv
// Top level of the next-fit extent allocator: joins the controller and the
// datapath. Uses nfea_pkg, nfea_ctrl and nfea_dpath.
`default_nettype none

// Keeps one used bit per block (NUM_BLOCKS = 1024) and a next-fit pointer.
// After reset the bitmap is swept clear, one block per cycle, so o_stall
// stays high until the whole map is clear and only then is the first word
// taken. Words are handled one at a time. A free, a zero size or an oversize
// request goes from acceptance through the dispatch and response states to
// the result register. An allocate scans the bitmap one block per cycle
// through the single registered read port, first from the pointer to the end
// of the map and, if nothing fits, again from block zero; it then marks the
// run one block per cycle through the same memory's write port. A finished
// result waits in the output register while the next word is accepted.
module next_fit_extent_allocator import nfea_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic                i_command,
    input  wire logic [SIZE_W-1:0]   i_request_size,
    input  wire logic [BADDR_W-1:0]  i_block_address,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [STATUS_W-1:0]      o_status,
    output logic [BADDR_W-1:0]       o_extent_first,
    output logic [BADDR_W-1:0]       o_extent_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    nfea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_stall (o_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    nfea_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_command       (i_command),
        .i_request_size  (i_request_size),
        .i_block_address (i_block_address),
        .i_out_stall     (i_stall),
        .o_out_valid     (o_valid),
        .o_status        (o_status),
        .o_extent_first  (o_extent_first),
        .o_extent_last   (o_extent_last)
    );

endmodule

`default_nettype wire

>>> hdl/nfea_checker.sv
// Port-level checks for the next-fit extent allocator and the bind that
// attaches them to the top level. Uses nfea_pkg.
`default_nettype none

module nfea_checker import nfea_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_stall,
    input wire logic                i_command,
    input wire logic [SIZE_W-1:0]   i_request_size,
    input wire logic [BADDR_W-1:0]  i_block_address,
    input wire logic                o_valid,
    input wire logic                i_stall,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [BADDR_W-1:0]  o_extent_first,
    input wire logic [BADDR_W-1:0]  o_extent_last
);

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_extent_first) && $stable(o_extent_last))
        else $error("result word changed while stalled");

    // block input right after each reset edge, as the clearing sweep begins
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input taken before the bitmap sweep");

    // a result with an error status carries no extent
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_DONE) |-> (o_extent_first == '0)
            && (o_extent_last == '0))
        else $error("error result with nonzero extent");

    // an extent never runs backward
    a_ext_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_DONE) |-> o_extent_first <= o_extent_last)
        else $error("extent first block after last block");

endmodule

bind next_fit_extent_allocator nfea_checker u_nfea_checker (.*);

`default_nettype wire

>>> tb/sv/nfea_extent_checker.sv
// Checker for the next-fit extent allocator: watches both channels, predicts
// each reply from its own bitmap and pointer, and compares. Uses nfea_pkg.
`timescale 1ns / 100ps

module nfea_extent_checker import nfea_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_stall,
    input  wire logic                i_command,
    input  wire logic [SIZE_W-1:0]   i_request_size,
    input  wire logic [BADDR_W-1:0]  i_block_address,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_stall,
    input  wire logic [STATUS_W-1:0] i_status,
    input  wire logic [BADDR_W-1:0]  i_extent_first,
    input  wire logic [BADDR_W-1:0]  i_extent_last,
    output int                       o_outstanding,
    output int                       o_mismatches
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BADDR_W-1:0]  ext_first;
        logic [BADDR_W-1:0]  ext_last;
    } t_extent_reply;

    // shadow of the allocator state
    bit            used_map [NUM_BLOCKS];
    int unsigned   next_fit_ptr = 0;

    t_extent_reply pending_replies [$];
    t_extent_reply oldest_reply;
    t_extent_reply seen_reply;
    int            words_in       = 0;
    int            words_out      = 0;
    int            mismatch_count = 0;

    assign o_outstanding = words_in - words_out;
    assign o_mismatches  = mismatch_count;

    // Find the first run of len free blocks that starts at or after from
    // and ends inside the map.
    function automatic bit find_free_run(input int unsigned from, input int unsigned len,
                                         output int unsigned start);
        int unsigned run_len = 0;
        start = 0;
        for (int unsigned b = from; b < NUM_BLOCKS; b++) begin
            if (used_map[b]) begin
                run_len = 0;
            end else begin
                run_len++;
                if (run_len == len) begin
                    start = b + 1 - len;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Apply one accepted word to the shadow state and return its reply.
    function automatic t_extent_reply predict_reply(input logic cmd,
                                                    input logic [SIZE_W-1:0] size,
                                                    input logic [BADDR_W-1:0] addr);
        t_extent_reply reply;
        int unsigned   len;
        int unsigned   start;
        int unsigned   stop;
        bit            hit;
        reply = '{status: ST_DONE, ext_first: '0, ext_last: '0};
        len   = 32'(size);
        if (cmd == CMD_FREE) begin
            if (addr < NUM_BLOCKS)
                used_map[addr] = 1'b0;
            return reply;
        end
        if (len == 0) begin
            reply.status = ST_ZERO;
            return reply;
        end
        if (len > NUM_BLOCKS) begin
            reply.status = ST_NOFIT;
            return reply;
        end
        if (next_fit_ptr >= NUM_BLOCKS)
            next_fit_ptr = 0;
        // search from the pointer first, then wrap once to block zero
        hit = find_free_run(next_fit_ptr, len, start);
        if (!hit)
            hit = find_free_run(0, len, start);
        if (!hit) begin
            reply.status = ST_NOFIT;
            return reply;
        end
        stop = start + len - 1;
        for (int unsigned b = start; b <= stop; b++)
            used_map[b] = 1'b1;
        next_fit_ptr    = (stop + 1 >= NUM_BLOCKS) ? 0 : stop + 1;
        reply.ext_first = BADDR_W'(start);
        reply.ext_last  = BADDR_W'(stop);
        return reply;
    endfunction

    // Compare replies first, then queue the prediction for a new word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (used_map[b])
                used_map[b] = 1'b0;
            next_fit_ptr = 0;
            pending_replies.delete();
            words_in       = 0;
            words_out      = 0;
            mismatch_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                words_out++;
                seen_reply = '{status: i_status, ext_first: i_extent_first,
                               ext_last: i_extent_last};
                if (pending_replies.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected reply: status %0d first %0d last %0d",
                                 seen_reply.status, seen_reply.ext_first,
                                 seen_reply.ext_last);
                end else begin
                    oldest_reply = pending_replies.pop_front();
                    if (seen_reply.status !== oldest_reply.status ||
                        seen_reply.ext_first !== oldest_reply.ext_first ||
                        seen_reply.ext_last !== oldest_reply.ext_last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("reply %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     words_out, oldest_reply.status,
                                     oldest_reply.ext_first, oldest_reply.ext_last,
                                     seen_reply.status, seen_reply.ext_first,
                                     seen_reply.ext_last);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_replies = {pending_replies,
                                   predict_reply(i_command, i_request_size,
                                                 i_block_address)};
                words_in++;
            end
        end
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the next-fit extent allocator testbench: clock, reset, directed and
// random command words, and the verdict. Uses nfea_pkg and nfea_extent_checker.
`timescale 1ns / 100ps

module testbench import nfea_pkg::*; ();

    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_WORDS  = 290;
    localparam int MAX_IDLE      = 3;
    localparam int SETTLE_CYCLES = 16;
    // clearing sweep plus every word at a full double scan, idles included,
    // taken several times over
    localparam int CYCLE_LIMIT   = NUM_BLOCKS + 4 * 320 * (3 * NUM_BLOCKS + 2 * MAX_IDLE + 16);

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_valid         = 1'b0;
    logic                o_stall;
    logic                i_command       = CMD_ALLOC;
    logic [SIZE_W-1:0]   i_request_size  = '0;
    logic [BADDR_W-1:0]  i_block_address = '0;
    logic                o_valid;
    logic                i_stall         = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [BADDR_W-1:0]  o_extent_first;
    logic [BADDR_W-1:0]  o_extent_last;

    int outstanding;
    int mismatches;
    int cycle_count = 0;
    int sent_words  = 0;
    bit calm_phase  = 1'b0;

    always #4 i_clk = ~i_clk;

    next_fit_extent_allocator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_request_size  (i_request_size),
        .i_block_address (i_block_address),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_extent_first  (o_extent_first),
        .o_extent_last   (o_extent_last)
    );

    nfea_extent_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_command       (i_command),
        .i_request_size  (i_request_size),
        .i_block_address (i_block_address),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_status        (o_status),
        .i_extent_first  (o_extent_first),
        .i_extent_last   (o_extent_last),
        .o_outstanding   (outstanding),
        .o_mismatches    (mismatches)
    );

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("next_fit_extent_allocator test failed");
            $finish;
        end
    end

    function automatic int draw_idle();
        return calm_phase ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    // Drive one word after a random gap and hold it until it is taken.
    // Called and returns at a falling edge.
    task automatic send_word(input logic cmd, input logic [SIZE_W-1:0] size,
                             input logic [BADDR_W-1:0] addr);
        int gap;
        gap = draw_idle();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= cmd;
        i_request_size  <= size;
        i_block_address <= addr;
        do @(posedge i_clk); while (o_stall);
        sent_words++;
        @(negedge i_clk);
    endtask

    // unused fields carry random junk
    task automatic alloc_extent(input int unsigned size);
        send_word(CMD_ALLOC, SIZE_W'(size), BADDR_W'($urandom_range(0, NUM_BLOCKS - 1)));
    endtask

    task automatic free_block(input int unsigned addr);
        send_word(CMD_FREE, SIZE_W'($urandom_range(0, 2 ** SIZE_W - 1)), BADDR_W'(addr));
    endtask

    task automatic free_span(input int unsigned start, input int unsigned len);
        for (int unsigned b = start; b < start + len && b < NUM_BLOCKS; b++)
            free_block(b);
    endtask

    // Result side: stall a random number of cycles per word, then take it
    initial begin
        int hold;
        forever begin
            hold = draw_idle();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int unsigned pick;
        int          target;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero size, oversize and the full map
        alloc_extent(0);
        alloc_extent(NUM_BLOCKS + 1);
        alloc_extent(2 ** SIZE_W - 1);
        alloc_extent(NUM_BLOCKS);
        alloc_extent(1);
        // free the top block twice, then block zero
        send_word(CMD_FREE, '1, '1);
        send_word(CMD_FREE, '0, '1);
        free_block(0);
        // two lone holes: no pair fits, singles land in order
        alloc_extent(2);
        send_word(CMD_ALLOC, 11'd1, '1);
        alloc_extent(1);
        // reuse a freed span, then fail when nothing is left free
        free_span(100, 4);
        alloc_extent(4);
        alloc_extent(3);
        // only a wrap to block zero finds this run
        free_span(10, 2);
        alloc_extent(2);
        // a run may not cross the end of the map
        free_span(NUM_BLOCKS - 2, 2);
        free_block(0);
        alloc_extent(3);

        // Random mix of allocations, mostly small, and frees of single blocks and spans
        target = sent_words + RANDOM_WORDS;
        while (sent_words < target) begin
            if ($urandom_range(0, 39) == 0)
                calm_phase = ~calm_phase;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                alloc_extent($urandom_range(0, 2 ** SIZE_W - 1));
            else if (pick < 7)
                alloc_extent(0);
            else if (pick < 12)
                alloc_extent($urandom_range(25, 300));
            else if (pick < 52)
                alloc_extent($urandom_range(1, 24));
            else if (pick < 85)
                free_block($urandom_range(0, NUM_BLOCKS - 1));
            else
                free_span($urandom_range(0, NUM_BLOCKS - 1), $urandom_range(2, 40));
        end
        i_valid <= 1'b0;

        // drain, then watch for stray replies
        while (outstanding != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0 && outstanding == 0)
            $display("next_fit_extent_allocator test passed");
        else
            $display("next_fit_extent_allocator test failed");
        $finish;
    end

endmodule
